>>> rtl/lcg_fisher_yates_shuffle_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shuffle unit checker.
// Concurrent checks that are disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef LCG_FISHER_YATES_SHUFFLE_UNIT_MACROS_SVH
`define LCG_FISHER_YATES_SHUFFLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFYS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shuffle unit check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LFYS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shuffle unit check failed one cycle later");

`endif

>>> rtl/lfys_pkg.sv
// ----------------------------------------------------------------------------
// lfys_pkg
// Shared types and constants of the shuffle unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfys_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int ENTRY_W         = 31;
  localparam int DATA_W          = 32;

  localparam logic [31:0] LCG_MUL      = 32'd1103515245;
  localparam logic [31:0] LCG_ADD      = 32'd12345;
  localparam logic [31:0] LCG_SEED_RST = 32'd1;

  localparam int DRAW_LSB = 16;
  localparam int DRAW_W   = 15;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAW,
    S_DIVGO,
    S_DIVW,
    S_RDA,
    S_RDB,
    S_WRA,
    S_WRB,
    S_ERD,
    S_EOUT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/lfys_lcg.sv
// ----------------------------------------------------------------------------
// lfys_lcg
// Linear congruential generator state, loaded by the seed register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfys_lcg
  import lfys_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              step,
  output logic      [DRAW_W-1:0] draw
);

  logic [31:0] rng_state_r;
  logic [31:0] rng_state_nxt;

  always_comb begin
    rng_state_nxt = rng_state_r;
    if (cfg_we) begin
      rng_state_nxt = cfg_wdata;
    end else if (step) begin
      rng_state_nxt = rng_state_r * LCG_MUL + LCG_ADD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_state_r <= LCG_SEED_RST;
    end else begin
      rng_state_r <= rng_state_nxt;
    end
  end

  assign draw = rng_state_r[DRAW_LSB +: DRAW_W];

endmodule

`default_nettype wire

>>> rtl/lfys_mod.sv
// ----------------------------------------------------------------------------
// lfys_mod
// Serial restoring modulo unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfys_mod
  import lfys_pkg::*;
#(
  parameter int CNT_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DRAW_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic      [CNT_W-1:0]  rem
);

  localparam int STEP_W = $clog2(DRAW_W);

  logic              busy_r;
  logic              busy_nxt;
  logic              done_r;
  logic              done_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [DRAW_W-1:0] dvd_r;
  logic [DRAW_W-1:0] dvd_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W-1:0]  dvs_nxt;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [CNT_W:0]    trial;

  always_comb begin
    trial    = {rem_r, dvd_r[DRAW_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DRAW_W - 1);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DRAW_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CNT_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[CNT_W-1:0];
      end
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> rtl/lfys_ram.sv
// ----------------------------------------------------------------------------
// lfys_ram
// Entry store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfys_ram
  import lfys_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_ENTRIES,
  parameter int AW    = $clog2(DEF_MAX_ENTRIES),
  parameter int WIDTH = ENTRY_W
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/lcg_fisher_yates_shuffle_unit.sv
// An entry not marked last is stored when accepted; in_tready is high again next cycle.
// A last entry with randomize set starts the shuffle, which draws a swap index for each stored entry
// with the 15-step modulo unit. Emission then reads each result beat and offers it, reading the next
// only once it is taken. No entries are taken during shuffle or emission.
// Synchronous active-low reset clears the group, the overflow flag and loads seed one.
// ----------------------------------------------------------------------------
// lcg_fisher_yates_shuffle_unit
// Collects a group of entries, optionally shuffles it and streams it out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcg_fisher_yates_shuffle_unit
  import lfys_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration: rng_seed.
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  // cpu_index[5:0], irq_number[14:6], hit_count[30:15], zero pad.
  input  wire logic [DATA_W-1:0] in_tdata,
  // randomize.
  input  wire logic              in_tuser,
  input  wire logic              in_tlast,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // out_cpu[5:0], out_irq[14:6], out_count[30:15], zero pad.
  output logic      [DATA_W-1:0] out_tdata,
  // overflow.
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready
);

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ENTRIES);

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   fill_nxt;
  logic               drop_r;
  logic               drop_nxt;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   idx_nxt;
  logic [AW-1:0]      j_r;
  logic [AW-1:0]      j_nxt;
  logic [ENTRY_W-1:0] tmp_r;
  logic [ENTRY_W-1:0] tmp_nxt;

  logic               in_acc;
  logic               room;
  logic [CNT_W-1:0]   group_n;
  logic [CNT_W-1:0]   top_idx;
  logic               emit_last;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               lcg_step;
  logic [DRAW_W-1:0]  draw;
  logic               div_start;
  logic               div_done;
  logic [CNT_W-1:0]   div_rem;

  assign in_acc    = in_tvalid && in_tready;
  assign room      = (fill_r < CAP);
  assign group_n   = room ? CNT_W'(fill_r + 1'b1) : fill_r;
  assign top_idx   = CNT_W'(idx_r - 1'b1);
  assign emit_last = (idx_r == CNT_W'(fill_r - 1'b1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tlast) begin
          state_nxt = in_tuser ? S_DRAW : S_ERD;
        end
      end
      S_DRAW:  state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: state_nxt = S_WRA;
      S_WRA: state_nxt = S_WRB;
      S_WRB: begin
        state_nxt = (idx_r == CNT_W'(1)) ? S_ERD : S_DRAW;
      end
      S_ERD: state_nxt = S_EOUT;
      S_EOUT: begin
        if (out_tready) begin
          state_nxt = emit_last ? S_IDLE : S_ERD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    lcg_step   = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = fill_r[AW-1:0];
    ram_wdata  = in_tdata[ENTRY_W-1:0];
    ram_re     = 1'b0;
    ram_raddr  = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ram_we    = in_tvalid && room;
      end
      S_DRAW:  lcg_step  = 1'b1;
      S_DIVGO: div_start = 1'b1;
      S_DIVW:  ;
      S_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = top_idx[AW-1:0];
      end
      S_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = j_r;
      end
      S_WRA: begin
        ram_we    = 1'b1;
        ram_waddr = top_idx[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = tmp_r;
      end
      S_ERD:  ram_re     = 1'b1;
      S_EOUT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    drop_nxt = drop_r;
    idx_nxt  = idx_r;
    j_nxt    = j_r;
    tmp_nxt  = tmp_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          fill_nxt = group_n;
          drop_nxt = drop_r || !room;
          idx_nxt  = in_tuser ? group_n : '0;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          j_nxt = div_rem[AW-1:0];
        end
      end
      S_RDB: tmp_nxt = ram_rdata;
      S_WRB: idx_nxt = top_idx;
      S_EOUT: begin
        if (out_tready) begin
          if (emit_last) begin
            fill_nxt = '0;
            drop_nxt = 1'b0;
          end else begin
            idx_nxt = CNT_W'(idx_r + 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      drop_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      drop_r  <= drop_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    tmp_r <= tmp_nxt;
  end

  lfys_lcg u_lcg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (lcg_step),
    .draw      (draw)
  );

  lfys_mod #(
    .CNT_W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (draw),
    .divisor  (idx_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  lfys_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {{(DATA_W - ENTRY_W){1'b0}}, ram_rdata};
  assign out_tuser = drop_r;
  assign out_tlast = emit_last;

endmodule

`default_nettype wire

>>> rtl/lfys_chk.sv
// ----------------------------------------------------------------------------
// lfys_chk
// Port-level checks of the shuffle unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lcg_fisher_yates_shuffle_unit_macros.svh"

module lfys_chk
  import lfys_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              in_tlast,
  input wire logic [DATA_W-1:0] out_tdata,
  input wire logic              out_tlast,
  input wire logic              out_tvalid,
  input wire logic              out_tready
);

  // The block never takes a new beat while a result is on offer.
  `LFYS_ASSERT_NOW(a_excl, clk, rst_n, in_tready, !out_tvalid)

  // An entry that does not end the group leaves the block ready again.
  `LFYS_ASSERT_NEXT(a_store_one, clk, rst_n, in_tvalid && in_tready && !in_tlast, in_tready)

  // After the final result of a group the block returns to taking entries.
  `LFYS_ASSERT_NEXT(a_group_end, clk, rst_n, out_tvalid && out_tready && out_tlast, in_tready)

  // A stalled result keeps its data.
  `LFYS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))

endmodule

bind lcg_fisher_yates_shuffle_unit lfys_chk u_lfys_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for lcg_fisher_yates_shuffle_unit
// Sends groups of priority entries with random gaps and receives the groups,
// shuffled or in order, under random back-pressure. An internal shuffle predictor
// keeps its own store, generator state and drop flag, and computes every
// result beat. Each received beat is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lfys_pkg::*;

  localparam int SETTLE_CYCLES = 30;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 20;

  typedef struct {
    logic [5:0]  cpu;
    logic [8:0]  irq;
    logic [15:0] cnt;
    logic        shuf;
    logic        last;
  } entry_beat_t;

  typedef struct {
    logic [5:0]  cpu;
    logic [8:0]  irq;
    logic [15:0] cnt;
    logic        last;
    logic        ovf;
  } group_emit_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [31:0]       cfg_wdata  = '0;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              in_tlast   = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              out_tvalid;
  logic              out_tready = 1'b0;

  entry_beat_t pending_beats[$];
  entry_beat_t next_beat;
  group_emit_t expected_emits[$];

  logic [30:0] entry_mem [DEF_MAX_ENTRIES];
  int          fill_cnt;
  logic [31:0] rng_state;
  logic        drop_flag;

  logic in_fire    = 1'b0;
  int   in_gap     = 0;
  int   stall_left = 0;
  bit   no_idle    = 1'b0;
  int   errors     = 0;
  int   cycle_count = 0;
  int   groups_done = 0;
  int   shuffled_groups = 0;
  int   overflow_groups = 0;
  int   results_checked = 0;

  lcg_fisher_yates_shuffle_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [8:0] pick_irq();
    if ($urandom_range(0, 5) == 0) return 9'h1FF;
    return 9'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  task automatic collect_entry(logic [5:0] cpu, logic [8:0] irq, logic [15:0] cnt,
                               logic shuf, logic last);
    int          n;
    int          j;
    logic [30:0] tmp;
    logic [14:0] d;
    group_emit_t emit;
    if (fill_cnt < DEF_MAX_ENTRIES) begin
      entry_mem[fill_cnt] = {cnt, irq, cpu};
      fill_cnt++;
    end else begin
      drop_flag = 1'b1;
    end
    if (!last) return;
    n = fill_cnt;
    if (shuf) begin
      for (int top = n - 1; top >= 0; top--) begin
        rng_state = rng_state * LCG_MUL + LCG_ADD;
        d = rng_state[DRAW_LSB +: DRAW_W];
        j = int'(d) % (top + 1);
        tmp = entry_mem[top];
        entry_mem[top] = entry_mem[j];
        entry_mem[j] = tmp;
      end
      shuffled_groups++;
    end
    for (int k = 0; k < n; k++) begin
      emit.cpu  = entry_mem[k][5:0];
      emit.irq  = entry_mem[k][14:6];
      emit.cnt  = entry_mem[k][30:15];
      emit.last = (k == n - 1);
      emit.ovf  = drop_flag;
      expected_emits.push_back(emit);
    end
    if (drop_flag) overflow_groups++;
    groups_done++;
    fill_cnt = 0;
    drop_flag = 1'b0;
  endtask

  always @(posedge clk) begin
    group_emit_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      fill_cnt = 0;
      rng_state = LCG_SEED_RST;
      drop_flag = 1'b0;
    end else begin
      if (cfg_we) rng_state = cfg_wdata;
      if (in_tvalid && in_tready)
        collect_entry(in_tdata[5:0], in_tdata[14:6], in_tdata[30:15], in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_emits.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected, expected none, got %h",
                     $time, out_tdata);
        end else begin
          want = expected_emits.pop_front();
          check_field("cpu", 32'(want.cpu), 32'(out_tdata[5:0]));
          check_field("irq", 32'(want.irq), 32'(out_tdata[14:6]));
          check_field("count", 32'(want.cnt), 32'(out_tdata[30:15]));
          check_field("last", 32'(want.last), 32'(out_tlast));
          check_field("overflow", 32'(want.ovf), 32'(out_tuser));
          results_checked++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        in_tdata  <= {1'b0, next_beat.cnt, next_beat.irq, next_beat.cpu};
        in_tuser  <= next_beat.shuf;
        in_tlast  <= next_beat.last;
        in_tvalid <= 1'b1;
        in_gap    <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL lcg_fisher_yates_shuffle_unit");
      $finish;
    end
  end

  task automatic push_beat(logic [5:0] cpu, logic [8:0] irq, logic [15:0] cnt,
                           logic shuf, logic last);
    entry_beat_t b;
    b.cpu  = cpu;
    b.irq  = irq;
    b.cnt  = cnt;
    b.shuf = shuf;
    b.last = last;
    pending_beats.push_back(b);
  endtask

  task automatic push_group(int n, logic shuf);
    for (int k = 0; k < n; k++)
      push_beat(6'($urandom_range(0, 63)), pick_irq(), 16'($urandom_range(0, 65535)),
                (k == n - 1) ? shuf : 1'($urandom_range(0, 1)), k == n - 1);
  endtask

  task automatic push_random_groups(int item_goal);
    int sent;
    int r;
    int n;
    sent = 0;
    while (sent < item_goal) begin
      r = $urandom_range(0, 9);
      if (r < 6) n = $urandom_range(1, 4);
      else if (r < 9) n = $urandom_range(5, 12);
      else n = $urandom_range(13, 30);
      push_group(n, $urandom_range(0, 9) < 7);
      sent += n;
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_tvalid || expected_emits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_beat(6'd0, 9'h1FF, 16'h0000, 1'b0, 1'b1);
    push_beat(6'd63, 9'd255, 16'hFFFF, 1'b1, 1'b1);
    push_beat(6'd1, 9'd0, 16'h0001, 1'b1, 1'b0);
    push_beat(6'd62, 9'h1FF, 16'h8000, 1'b1, 1'b0);
    push_beat(6'd21, 9'd128, 16'h7FFF, 1'b0, 1'b1);
    push_beat(6'd42, 9'd85, 16'hAAAA, 1'b0, 1'b0);
    push_beat(6'd10, 9'd170, 16'h5555, 1'b0, 1'b0);
    push_beat(6'd33, 9'h1FF, 16'h00FF, 1'b1, 1'b0);
    push_beat(6'd5, 9'd1, 16'hFF00, 1'b0, 1'b0);
    push_beat(6'd60, 9'd254, 16'h1234, 1'b1, 1'b1);
    wait_idle();
    write_seed(32'h0000_0000);
    push_group(4, 1'b1);
    push_group(2, 1'b1);
    wait_idle();
    write_seed(32'hFFFF_FFFF);
    push_group(3, 1'b1);
    push_group(1, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_seed(32'h8000_0000);
        1: write_seed($urandom());
        2: write_seed(32'h7FFF_FFFF);
        default: write_seed($urandom());
      endcase
      no_idle = (phase == 1);
      push_random_groups(8);
      if (phase == 2) push_group(66, 1'b1);
      push_random_groups(8);
      wait_idle();
    end

    $display("Checked %0d result beats from %0d groups: %0d shuffled, %0d with dropped entries.",
             results_checked, groups_done, shuffled_groups, overflow_groups);
    $display("Seeds covered reset value, zero, all ones, both sign extremes and random values.");
    if (errors == 0) begin
      $display("PASS lcg_fisher_yates_shuffle_unit");
    end else begin
      $display("FAIL lcg_fisher_yates_shuffle_unit");
    end
    $finish;
  end

endmodule

>>> lcg_fisher_yates_shuffle_unit.f
+incdir+rtl
rtl/lfys_pkg.sv
rtl/lfys_lcg.sv
rtl/lfys_mod.sv
rtl/lfys_ram.sv
rtl/lcg_fisher_yates_shuffle_unit.sv
rtl/lfys_chk.sv
test/tb.sv
